### hdl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Types and constants shared by the touch gesture recognizer modules.
// ----------------------------------------------------------------------------
package tgr_pkg;

   localparam int COORD_W     = 12;
   localparam int TIME_W      = 48;
   localparam int FINGER_W    = 4;
   localparam int DIST_W      = 12;
   localparam int DUR_W       = 24;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;

   localparam logic [DIST_W-1:0] SWIPE_DISTANCE_RST    = DIST_W'(60);
   localparam logic [DIST_W-1:0] HOLD_MOVE_LIMIT_RST   = DIST_W'(30);
   localparam logic [DUR_W-1:0]  TAP_MAX_TIME_RST      = DUR_W'(450000);
   localparam logic [DUR_W-1:0]  DOUBLE_TAP_WINDOW_RST = DUR_W'(380000);
   localparam logic [DUR_W-1:0]  LONG_PRESS_TIME_RST   = DUR_W'(700000);

   typedef enum logic [2:0] {
      GEST_NONE   = 3'd0,
      GEST_TAP    = 3'd1,
      GEST_DOUBLE = 3'd2,
      GEST_LONG   = 3'd3,
      GEST_LEFT   = 3'd4,
      GEST_RIGHT  = 3'd5,
      GEST_UP     = 3'd6,
      GEST_DOWN   = 3'd7
   } tgr_gesture_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CANCEL = 1'b1
   } tgr_op_type;

   typedef struct packed {
      tgr_op_type          op;
      logic                sample_ok;
      logic [FINGER_W-1:0] finger_count;
      logic [COORD_W-1:0]  touch_x;
      logic [COORD_W-1:0]  touch_y;
      logic [TIME_W-1:0]   now_us;
   } tgr_req_type;

   typedef struct packed {
      tgr_gesture_type    gesture;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
   } tgr_rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0] swipe_distance;
      logic [DIST_W-1:0] hold_move_limit;
      logic [DUR_W-1:0]  tap_max_time;
      logic [DUR_W-1:0]  double_tap_window;
      logic [DUR_W-1:0]  long_press_time;
   } tgr_cfg_type;

   typedef struct packed {
      logic               is_pressed;
      logic               long_reported;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] last_x;
      logic [COORD_W-1:0] last_y;
      logic [TIME_W-1:0]  press_time;
      logic               tap_waiting;
      logic [COORD_W-1:0] tap_x;
      logic [COORD_W-1:0] tap_y;
      logic [TIME_W-1:0]  tap_time;
   } tgr_state_type;

endpackage

### hdl/tgr_csr.sv
// ----------------------------------------------------------------------------
// tgr_csr
// Configuration registers behind an APB-style write and read port.
// ----------------------------------------------------------------------------
module tgr_csr
   import tgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output tgr_cfg_type           cfg
);

   typedef enum logic [2:0] {
      IDX_SWIPE_DISTANCE    = 3'd0,
      IDX_HOLD_MOVE_LIMIT   = 3'd1,
      IDX_TAP_MAX_TIME      = 3'd2,
      IDX_DOUBLE_TAP_WINDOW = 3'd3,
      IDX_LONG_PRESS_TIME   = 3'd4
   } csr_index_type;

   tgr_cfg_type   cfg_ff;
   tgr_cfg_type   cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            IDX_SWIPE_DISTANCE:    cfg_in.swipe_distance    = pwdata[DIST_W-1:0];
            IDX_HOLD_MOVE_LIMIT:   cfg_in.hold_move_limit   = pwdata[DIST_W-1:0];
            IDX_TAP_MAX_TIME:      cfg_in.tap_max_time      = pwdata[DUR_W-1:0];
            IDX_DOUBLE_TAP_WINDOW: cfg_in.double_tap_window = pwdata[DUR_W-1:0];
            IDX_LONG_PRESS_TIME:   cfg_in.long_press_time   = pwdata[DUR_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         IDX_SWIPE_DISTANCE:    prdata = CSR_DATA_W'(cfg_ff.swipe_distance);
         IDX_HOLD_MOVE_LIMIT:   prdata = CSR_DATA_W'(cfg_ff.hold_move_limit);
         IDX_TAP_MAX_TIME:      prdata = CSR_DATA_W'(cfg_ff.tap_max_time);
         IDX_DOUBLE_TAP_WINDOW: prdata = CSR_DATA_W'(cfg_ff.double_tap_window);
         IDX_LONG_PRESS_TIME:   prdata = CSR_DATA_W'(cfg_ff.long_press_time);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_distance    <= SWIPE_DISTANCE_RST;
         cfg_ff.hold_move_limit   <= HOLD_MOVE_LIMIT_RST;
         cfg_ff.tap_max_time      <= TAP_MAX_TIME_RST;
         cfg_ff.double_tap_window <= DOUBLE_TAP_WINDOW_RST;
         cfg_ff.long_press_time   <= LONG_PRESS_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/tgr_eval.sv
// ----------------------------------------------------------------------------
// tgr_eval
// Gesture decision for one request against the current press and tap state.
// ----------------------------------------------------------------------------
module tgr_eval
   import tgr_pkg::*;
(
   input  tgr_req_type   req,
   input  tgr_state_type state,
   input  tgr_cfg_type   cfg,
   output tgr_state_type state_next,
   output tgr_rsp_type   rsp
);

   logic               contact;
   logic               new_press;
   logic               hold;
   logic               release_ev;
   logic [TIME_W-1:0]  el_press;
   logic [TIME_W-1:0]  el_tap;
   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;
   logic [COORD_W:0]   dx;
   logic [COORD_W:0]   dy;
   logic [COORD_W-1:0] ax;
   logic [COORD_W-1:0] ay;
   logic               long_hit;
   logic               swipe_hit;
   logic               tap_ok;
   logic               dbl_hit;
   logic               tap_set;
   logic               done;
   logic               single_hit;

   assign contact    = req.finger_count != '0;
   assign new_press  = contact & ~state.is_pressed;
   assign hold       = contact & state.is_pressed;
   assign release_ev = ~contact & state.is_pressed;

   assign el_press = req.now_us - state.press_time;
   assign el_tap   = req.now_us - state.tap_time;

   assign cur_x = hold ? req.touch_x : state.last_x;
   assign cur_y = hold ? req.touch_y : state.last_y;
   assign dx    = {1'b0, cur_x} - {1'b0, state.start_x};
   assign dy    = {1'b0, cur_y} - {1'b0, state.start_y};
   assign ax    = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
   assign ay    = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

   assign long_hit  = hold & ~state.long_reported
                    & (el_press >= TIME_W'(cfg.long_press_time))
                    & (ax < cfg.hold_move_limit) & (ay < cfg.hold_move_limit);
   assign swipe_hit = release_ev & ~state.long_reported
                    & ((ax >= cfg.swipe_distance) | (ay >= cfg.swipe_distance));
   assign tap_ok    = release_ev & ~state.long_reported & ~swipe_hit
                    & (el_press <= TIME_W'(cfg.tap_max_time));
   assign dbl_hit   = tap_ok & state.tap_waiting
                    & (el_tap <= TIME_W'(cfg.double_tap_window));
   assign tap_set   = tap_ok & ~dbl_hit;
   assign done      = long_hit | (release_ev & state.long_reported) | swipe_hit | dbl_hit;
   assign single_hit = ~done & ~tap_set & state.tap_waiting & ~contact
                     & (el_tap > TIME_W'(cfg.double_tap_window));

   always_comb begin
      state_next  = state;
      rsp.gesture = GEST_NONE;
      rsp.out_x   = '0;
      rsp.out_y   = '0;
      if (req.op == OP_CANCEL) begin
         state_next.is_pressed    = 1'b0;
         state_next.long_reported = 1'b0;
         state_next.tap_waiting   = 1'b0;
      end else if (req.sample_ok) begin
         if (new_press) begin
            state_next.is_pressed    = 1'b1;
            state_next.long_reported = 1'b0;
            state_next.start_x       = req.touch_x;
            state_next.start_y       = req.touch_y;
            state_next.last_x        = req.touch_x;
            state_next.last_y        = req.touch_y;
            state_next.press_time    = req.now_us;
         end
         if (hold) begin
            state_next.last_x = req.touch_x;
            state_next.last_y = req.touch_y;
         end
         if (release_ev) begin
            state_next.is_pressed = 1'b0;
         end
         if (long_hit) begin
            state_next.long_reported = 1'b1;
            state_next.tap_waiting   = 1'b0;
            rsp.gesture              = GEST_LONG;
            rsp.out_x                = req.touch_x;
            rsp.out_y                = req.touch_y;
         end
         if (swipe_hit) begin
            state_next.tap_waiting = 1'b0;
            if (ax > ay) begin
               rsp.gesture = dx[COORD_W] || dx == '0 ? GEST_LEFT : GEST_RIGHT;
            end else begin
               rsp.gesture = dy[COORD_W] || dy == '0 ? GEST_UP : GEST_DOWN;
            end
         end
         if (dbl_hit) begin
            state_next.tap_waiting = 1'b0;
            rsp.gesture            = GEST_DOUBLE;
            rsp.out_x              = state.last_x;
            rsp.out_y              = state.last_y;
         end
         if (tap_set) begin
            state_next.tap_waiting = 1'b1;
            state_next.tap_x       = state.last_x;
            state_next.tap_y       = state.last_y;
            state_next.tap_time    = req.now_us;
         end
         if (single_hit) begin
            state_next.tap_waiting = 1'b0;
            rsp.gesture            = GEST_TAP;
            rsp.out_x              = state.tap_x;
            rsp.out_y              = state.tap_y;
         end
      end
   end

endmodule

### hdl/touch_gesture_recognizer_core.sv
// Pipeline: an accepted request is held in the request register req_ff, and its result
// is registered in the result register rsp_ff, which drives rsp_data.
// Throughput: one request per cycle; the request register and the result register
// advance together whenever the result register is empty or its result is taken.
// Reset: synchronous, active high; clears the gesture state, empties both stages
// and restores the configuration defaults.
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_core
// Tap, double tap, long press and four-way swipe recognizer, top level.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_core
   import tgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tgr_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tgr_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   tgr_cfg_type   cfg;
   tgr_state_type state_ff;
   tgr_state_type state_in;
   tgr_state_type state_calc;
   tgr_req_type   req_ff;
   tgr_req_type   req_in;
   logic          req_valid_ff;
   logic          req_valid_in;
   tgr_rsp_type   rsp_ff;
   tgr_rsp_type   rsp_in;
   tgr_rsp_type   rsp_calc;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          advance;

   tgr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgr_eval u_eval (
      .req        (req_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_calc),
      .rsp        (rsp_calc)
   );

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = req_valid_ff & ~advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            rsp_in   = rsp_calc;
            state_in = state_calc;
         end
      end
      if (~req_stall) begin
         req_valid_in = req_valid;
         req_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

### hdl/tgr_checker.sv
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks for the touch gesture recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module tgr_checker
   import tgr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input tgr_rsp_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.gesture == GEST_NONE || rsp_data.gesture == GEST_LEFT ||
                    rsp_data.gesture == GEST_RIGHT || rsp_data.gesture == GEST_UP ||
                    rsp_data.gesture == GEST_DOWN)
      |-> rsp_data.out_x == '0 && rsp_data.out_y == '0)
      else $error("coordinates on a result without position");

endmodule

bind touch_gesture_recognizer_core tgr_checker u_tgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### test/tb_touch_gesture_recognizer_core.sv
// ----------------------------------------------------------------------------
// tb_touch_gesture_recognizer_core
// Self-checking bench for the touch gesture recognizer. A scoreboard class
// tracks the press, tap and long-press state and predicts the gesture of every
// accepted request; each result is compared in order. A short directed run
// covers every gesture and corner case, then random strokes near the timing
// and travel thresholds run under several register settings, written between
// phases through the APB port and read back, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_touch_gesture_recognizer_core;
   import tgr_pkg::*;

   localparam int REG_SWIPE_DISTANCE    = 0;
   localparam int REG_HOLD_MOVE_LIMIT   = 1;
   localparam int REG_TAP_MAX_TIME      = 2;
   localparam int REG_DOUBLE_TAP_WINDOW = 3;
   localparam int REG_LONG_PRESS_TIME   = 4;
   localparam int REG_COUNT             = 5;

   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int IDLE_LIMIT      = 2000;

   class gesture_scoreboard;
      tgr_cfg_type   cfg;
      tgr_state_type st;
      tgr_rsp_type   pending_gestures[$];
      int            mismatches;

      function new();
         cfg = '{SWIPE_DISTANCE_RST, HOLD_MOVE_LIMIT_RST, TAP_MAX_TIME_RST,
                 DOUBLE_TAP_WINDOW_RST, LONG_PRESS_TIME_RST};
         st = '0;
         mismatches = 0;
      endfunction

      function void mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", what);
      endfunction

      function void set_register(int idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SWIPE_DISTANCE:    cfg.swipe_distance    = value[DIST_W-1:0];
            REG_HOLD_MOVE_LIMIT:   cfg.hold_move_limit   = value[DIST_W-1:0];
            REG_TAP_MAX_TIME:      cfg.tap_max_time      = value[DUR_W-1:0];
            REG_DOUBLE_TAP_WINDOW: cfg.double_tap_window = value[DUR_W-1:0];
            REG_LONG_PRESS_TIME:   cfg.long_press_time   = value[DUR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] register_value(int idx);
         case (idx)
            REG_SWIPE_DISTANCE:    return CSR_DATA_W'(cfg.swipe_distance);
            REG_HOLD_MOVE_LIMIT:   return CSR_DATA_W'(cfg.hold_move_limit);
            REG_TAP_MAX_TIME:      return CSR_DATA_W'(cfg.tap_max_time);
            REG_DOUBLE_TAP_WINDOW: return CSR_DATA_W'(cfg.double_tap_window);
            default:               return CSR_DATA_W'(cfg.long_press_time);
         endcase
      endfunction

      function logic [TIME_W-1:0] span(logic [TIME_W-1:0] later, logic [TIME_W-1:0] earlier);
         return later - earlier;
      endfunction

      function void note_request(tgr_req_type r);
         tgr_rsp_type res;
         logic        contact;
         logic        finished;
         int          dx, dy, ax, ay;
         res = '{GEST_NONE, '0, '0};
         finished = 1'b0;
         if (r.op == OP_CANCEL) begin
            st.is_pressed    = 1'b0;
            st.long_reported = 1'b0;
            st.tap_waiting   = 1'b0;
         end else if (r.sample_ok) begin
            contact = (r.finger_count != '0);
            if (contact && st.is_pressed) begin
               st.last_x = r.touch_x;
               st.last_y = r.touch_y;
            end
            dx = int'(st.last_x) - int'(st.start_x);
            dy = int'(st.last_y) - int'(st.start_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (contact && !st.is_pressed) begin
               st.is_pressed    = 1'b1;
               st.long_reported = 1'b0;
               st.start_x       = r.touch_x;
               st.start_y       = r.touch_y;
               st.last_x        = r.touch_x;
               st.last_y        = r.touch_y;
               st.press_time    = r.now_us;
            end else if (contact) begin
               if (!st.long_reported && span(r.now_us, st.press_time) >= cfg.long_press_time
                   && ax < cfg.hold_move_limit && ay < cfg.hold_move_limit) begin
                  st.long_reported = 1'b1;
                  st.tap_waiting   = 1'b0;
                  res = '{GEST_LONG, st.last_x, st.last_y};
                  finished = 1'b1;
               end
            end else if (st.is_pressed) begin
               st.is_pressed = 1'b0;
               if (st.long_reported) begin
                  finished = 1'b1;
               end else if (ax >= cfg.swipe_distance || ay >= cfg.swipe_distance) begin
                  st.tap_waiting = 1'b0;
                  if (ax > ay) res.gesture = (dx > 0) ? GEST_RIGHT : GEST_LEFT;
                  else res.gesture = (dy > 0) ? GEST_DOWN : GEST_UP;
                  finished = 1'b1;
               end else if (span(r.now_us, st.press_time) <= cfg.tap_max_time) begin
                  if (st.tap_waiting
                      && span(r.now_us, st.tap_time) <= cfg.double_tap_window) begin
                     st.tap_waiting = 1'b0;
                     res = '{GEST_DOUBLE, st.last_x, st.last_y};
                     finished = 1'b1;
                  end else begin
                     st.tap_waiting = 1'b1;
                     st.tap_x       = st.last_x;
                     st.tap_y       = st.last_y;
                     st.tap_time    = r.now_us;
                  end
               end
            end
            if (!finished && st.tap_waiting && !st.is_pressed
                && span(r.now_us, st.tap_time) > cfg.double_tap_window) begin
               st.tap_waiting = 1'b0;
               res = '{GEST_TAP, st.tap_x, st.tap_y};
            end
         end
         pending_gestures.push_back(res);
      endfunction

      function void check_result(tgr_rsp_type got);
         tgr_rsp_type want;
         if (pending_gestures.size() == 0) begin
            mismatch($sformatf("unexpected result gesture %0d x %0d y %0d",
                               got.gesture, got.out_x, got.out_y));
            return;
         end
         want = pending_gestures.pop_front();
         if (got.gesture !== want.gesture || got.out_x !== want.out_x
             || got.out_y !== want.out_y)
            mismatch($sformatf("gesture exp %0d got %0d, x exp %0d got %0d, y exp %0d got %0d",
                               want.gesture, got.gesture, want.out_x, got.out_x,
                               want.out_y, got.out_y));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   tgr_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   tgr_rsp_type           rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gesture_scoreboard sb;
   logic [TIME_W-1:0] cur_time = '0;
   int                items_sent = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   int                stall_mode = STALL_NONE;
   int                stall_span = 0;
   logic [1:0]        stall_phase = '0;

   touch_gesture_recognizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_PATTERN);
         stall_span <= $urandom_range(16, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_phase <= stall_phase + 2'd1;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
         default:      rsp_stall <= (stall_phase != 2'b11);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic logic [COORD_W-1:0] clip(int v);
      if (v < 0) return '0;
      if (v > (1 << COORD_W) - 1) return '1;
      return COORD_W'(v);
   endfunction

   function automatic int unsigned near(int unsigned limit);
      case ($urandom_range(0, 5))
         0:       return limit;
         1:       return limit + 1;
         2:       return (limit == 0) ? 0 : limit - 1;
         3:       return $urandom_range(0, limit);
         4:       return limit + $urandom_range(0, limit);
         default: return $urandom_range(0, 2000);
      endcase
   endfunction

   function automatic int travel(int limit);
      int mag;
      case ($urandom_range(0, 4))
         0:       mag = limit;
         1:       mag = limit - 1;
         2:       mag = limit + 1;
         3:       mag = $urandom_range(0, limit);
         default: mag = $urandom_range(0, (1 << COORD_W) - 1);
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic tgr_req_type random_request(tgr_op_type op, logic ok);
      return '{op, ok, FINGER_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               TIME_W'({$urandom, $urandom})};
   endfunction

   function automatic logic [DUR_W-1:0] pick_limit(int unsigned max_value);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return DUR_W'(max_value);
         2:       return DUR_W'($urandom_range(0, max_value / 64));
         default: return DUR_W'($urandom_range(0, max_value));
      endcase
   endfunction

   task automatic send_item(tgr_req_type item);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic push_sample(logic [FINGER_W-1:0] fingers, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y);
      if ($urandom_range(0, 24) == 0) send_item(random_request(OP_SAMPLE, 1'b0));
      send_item('{OP_SAMPLE, 1'b1, fingers, x, y, cur_time});
   endtask

   task automatic stroke(int x0, int y0, int x1, int y1, int unsigned interval, int mids,
                         int unsigned tail);
      push_sample(FINGER_W'($urandom_range(1, 15)), clip(x0), clip(y0));
      for (int i = 1; i <= mids; i++) begin
         cur_time += interval;
         push_sample(FINGER_W'($urandom_range(1, 15)), clip(x0 + (x1 - x0) * i / mids),
                     clip(y0 + (y1 - y0) * i / mids));
      end
      cur_time += tail;
      push_sample('0, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending_gestures.size() != 0);
   endtask

   task automatic csr_access(logic write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic apply_config(tgr_cfg_type c);
      logic [CSR_DATA_W-1:0] word, readback;
      for (int i = 0; i <= REG_COUNT; i++) begin
         word = $urandom;
         case (i)
            REG_SWIPE_DISTANCE:    word[DIST_W-1:0] = c.swipe_distance;
            REG_HOLD_MOVE_LIMIT:   word[DIST_W-1:0] = c.hold_move_limit;
            REG_TAP_MAX_TIME:      word[DUR_W-1:0]  = c.tap_max_time;
            REG_DOUBLE_TAP_WINDOW: word[DUR_W-1:0]  = c.double_tap_window;
            REG_LONG_PRESS_TIME:   word[DUR_W-1:0]  = c.long_press_time;
            default: ;
         endcase
         sb.set_register(i, word);
         csr_access(1'b1, CSR_ADDR_W'(4 * i), word, readback);
      end
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_access(1'b0, CSR_ADDR_W'(4 * i), '0, readback);
         if (readback !== sb.register_value(i))
            sb.mismatch($sformatf("register %0d reads %0h, expected %0h",
                                  i, readback, sb.register_value(i)));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(random_request(OP_CANCEL, 1'($urandom_range(0, 1))));
      send_item('{OP_SAMPLE, 1'b0, '1, '1, '1, '1});
      cur_time = TIME_W'(1000);
      stroke(0, 0, 0, 0, 0, 0, 100000);
      cur_time += 100000;
      stroke(4095, 0, 4095, 0, 0, 0, 50000);
      cur_time += 1000000;
      stroke(4095, 4095, 4095, 4095, 700000, 1, 100000);
      cur_time += 1000000;
      stroke(2000, 2000, 2100, 2010, 50000, 1, 50000);
      stroke(2000, 2000, 1900, 1990, 50000, 1, 50000);
      stroke(2000, 2000, 2010, 1900, 50000, 1, 50000);
      stroke(2000, 2000, 1990, 2100, 50000, 1, 50000);
      stroke(500, 500, 600, 400, 50000, 1, 50000);
      cur_time += 1000000;
      stroke(10, 4095, 10, 4095, 0, 0, 1000);
      cur_time += 400000;
      push_sample('0, '0, '0);
      cur_time = '1 - TIME_W'(49);
      stroke(7, 7, 7, 7, 0, 0, 100);
   endtask

   task automatic play_gesture();
      int          x0, y0, x1, y1, mids;
      int unsigned interval;
      x0 = $urandom_range(0, (1 << COORD_W) - 1);
      y0 = $urandom_range(0, (1 << COORD_W) - 1);
      x1 = x0 + travel(sb.cfg.swipe_distance);
      y1 = y0 + travel(sb.cfg.swipe_distance);
      mids = $urandom_range(0, 3);
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            interval = near(sb.cfg.tap_max_time) / (mids + 1);
            stroke(x0, y0, x1, y1, interval, mids, interval);
         end
         3, 4: begin
            stroke(x0, y0, x0, y0, 0, 0, near(sb.cfg.tap_max_time));
            cur_time += near(sb.cfg.double_tap_window);
            stroke(x0 + travel(sb.cfg.hold_move_limit), y0 + travel(sb.cfg.hold_move_limit),
                   x0, y0, 0, 0, $urandom_range(0, 1) ? near(sb.cfg.tap_max_time) : 0);
         end
         5, 6: begin
            mids = $urandom_range(1, 4);
            interval = (near(sb.cfg.long_press_time) + mids - 1) / mids;
            stroke(x0, y0, x0 + travel(sb.cfg.hold_move_limit),
                   y0 + travel(sb.cfg.hold_move_limit), interval, mids,
                   near(sb.cfg.tap_max_time));
         end
         7, 8: begin
            mids = $urandom_range(1, 3);
            stroke(x0, y0, x1, y0 + travel($urandom_range(0, 4095)),
                   $urandom_range(0, 100000), mids, $urandom_range(0, 100000));
         end
         9: begin
            repeat ($urandom_range(1, 3)) begin
               cur_time += near(sb.cfg.double_tap_window);
               push_sample('0, COORD_W'($urandom), COORD_W'($urandom));
            end
         end
         10: begin
            push_sample(FINGER_W'($urandom_range(1, 15)), clip(x0), clip(y0));
            cur_time += near(sb.cfg.long_press_time);
            send_item(random_request(OP_CANCEL, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 1)) push_sample('0, clip(x1), clip(y1));
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               cur_time = '1 - TIME_W'(near(sb.cfg.tap_max_time));
               stroke(x0, y0, x0, y0, 0, 0, near(sb.cfg.tap_max_time));
            end else begin
               send_item(random_request(tgr_op_type'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
            end
         end
      endcase
   endtask

   initial begin
      tgr_cfg_type setting;
      int          target;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1:        setting = '0;
               2:        setting = '1;
               PHASES-1: setting = '{SWIPE_DISTANCE_RST, HOLD_MOVE_LIMIT_RST,
                                     TAP_MAX_TIME_RST, DOUBLE_TAP_WINDOW_RST,
                                     LONG_PRESS_TIME_RST};
               default:  setting = '{DIST_W'(pick_limit(4095)), DIST_W'(pick_limit(4095)),
                                     pick_limit(24'hFFFFFF), pick_limit(24'hFFFFFF),
                                     pick_limit(24'hFFFFFF)};
            endcase
            apply_config(setting);
         end
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) play_gesture();
      end
      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_gestures.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
